### rtl/ima_adpcm_multichannel_encoder_assert.svh
// Assertion macros shared by the encoder's checker
`ifndef IMA_ADPCM_MULTICHANNEL_ENCODER_ASSERT_SVH
`define IMA_ADPCM_MULTICHANNEL_ENCODER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define IMAENC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IMAENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/imaenc_pkg.sv
// Shared types, codes and the IMA ADPCM nibble encoder function
`default_nettype none

package imaenc_pkg;

  // channel_mode register codes, also used as the frame kind in the queue
  typedef logic [1:0] kind_t;
  localparam kind_t KindMono   = 2'd0;
  localparam kind_t KindStereo = 2'd1;
  localparam kind_t KindQuad   = 2'd2;

  localparam logic [6:0] MaxStepPos = 7'd88;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic signed [15:0] sample_c;
    logic signed [15:0] sample_d;
  } frame_t;

  // front -> queue
  typedef struct packed {
    logic   push;
    frame_t frame;
  } push_t;

  // queue -> back
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } head_t;

  typedef struct packed {
    logic [3:0]         code;
    logic signed [15:0] pred;
    logic [6:0]         pos;
  } enc_res_t;

  function automatic logic [14:0] step_size(logic [6:0] p);
    logic [14:0] s;
    case (p)
      7'd0: s = 15'd7;      7'd1: s = 15'd8;      7'd2: s = 15'd9;      7'd3: s = 15'd10;
      7'd4: s = 15'd11;     7'd5: s = 15'd12;     7'd6: s = 15'd13;     7'd7: s = 15'd14;
      7'd8: s = 15'd16;     7'd9: s = 15'd17;     7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(logic [2:0] c);
    logic signed [4:0] a;
    case (c)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

  // One IMA ADPCM step: difference at 17 bits, three compare/subtract
  // stages, saturating predictor update, clamped index update.
  function automatic enc_res_t encode_nibble(logic signed [15:0] smp,
                                             logic signed [15:0] pred,
                                             logic [6:0]         pos);
    logic [6:0]         p;
    logic [14:0]        step;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [15:0]        delta;
    logic [3:0]         code;
    logic signed [17:0] np;
    logic signed [8:0]  ni;
    enc_res_t           r;
    p     = (pos > MaxStepPos) ? MaxStepPos : pos;
    step  = step_size(p);
    diff  = $signed({smp[15], smp}) - $signed({pred[15], pred});
    code  = 4'd0;
    if (diff < 0) begin
      code[3] = 1'b1;
      mag     = 17'(-diff);
    end else begin
      mag = 17'(diff);
    end
    delta = {4'd0, step[14:3]};
    if (mag >= {2'd0, step}) begin
      code[2] = 1'b1;
      mag     = mag - {2'd0, step};
      delta   = delta + {1'b0, step};
    end
    if (mag >= {3'd0, step[14:1]}) begin
      code[1] = 1'b1;
      mag     = mag - {3'd0, step[14:1]};
      delta   = delta + {2'd0, step[14:1]};
    end
    if (mag >= {4'd0, step[14:2]}) begin
      code[0] = 1'b1;
      delta   = delta + {3'd0, step[14:2]};
    end
    if (code[3]) begin
      np = $signed({{2{pred[15]}}, pred}) - $signed({2'd0, delta});
    end else begin
      np = $signed({{2{pred[15]}}, pred}) + $signed({2'd0, delta});
    end
    if (np < -18'sd32768) begin
      r.pred = 16'sh8000;
    end else if (np > 18'sd32767) begin
      r.pred = 16'sh7fff;
    end else begin
      r.pred = np[15:0];
    end
    ni = $signed({2'd0, p}) + 9'(index_adjust(code[2:0]));
    if (ni < 0) begin
      r.pos = 7'd0;
    end else if (ni > $signed({2'd0, MaxStepPos})) begin
      r.pos = MaxStepPos;
    end else begin
      r.pos = ni[6:0];
    end
    r.code = code;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/ima_adpcm_multichannel_encoder.sv
// Top level: 4-channel IMA ADPCM encoder with APB mode register
// Output bytes are registered; mono encodes its two samples on channel 0
// in two passes and registers its byte on the second pass.
// Throughput: stereo one frame per cycle unless the output stalls; mono
// and quad take two encode passes each (quad's second pass emits a second byte).
// Reset (rst, synchronous): mode mono, channel state zero, queue empty, no output.
`default_nettype none

module ima_adpcm_multichannel_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst,
  // input frames
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // sample_a[15:0], sample_b[31:16],
                                     // sample_c[47:32], sample_d[63:48]
  // code bytes
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // code_byte[7:0]
  output logic        m_axis_tuser,  // pair_select
  output logic        m_axis_tlast,  // last_of_frame
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import imaenc_pkg::*;

  kind_t  channel_mode;
  push_t  push;
  head_t  head;
  logic   queue_full;
  logic   pop;
  logic   reg_sel;

  // ---------------------------------------------------------------------
  // APB register: channel_mode at byte address 0; paddr[2] picks the
  // register, anything past it is ignored on write and reads as zero. The user must see that Mode
  // is only written while idle, so frames in flight never see it move; the block does not enforce it.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {30'd0, channel_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mode <= KindMono;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      channel_mode <= pwdata[1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Front end: takes a transfer whenever the queue has room and reset is
  // released, tags the frame with the current mode, drops it when the mode
  // code is unused.
  // ---------------------------------------------------------------------
  imaenc_front u_front (
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .channel_mode  (channel_mode),
    .queue_full    (queue_full),
    .push          (push)
  );

  // ---------------------------------------------------------------------
  // Queue decouples input stalls from output stalls.
  // ---------------------------------------------------------------------
  imaenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  // ---------------------------------------------------------------------
  // Back end: two lanes encode up to one byte per cycle into the output
  // register while the output is not stalled. Mono encodes its two samples
  // on channel 0 in two passes, one per cycle unless the output stalls; quad
  // takes two passes (front pair, then center/LFE) before popping the frame.
  // ---------------------------------------------------------------------
  imaenc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### rtl/imaenc_front.sv
// Front end: accepts frames, tags them with the channel mode, drops unused mode
`default_nettype none

module imaenc_front (
  input  wire                      rst,
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire  [63:0]              s_axis_tdata,
  input  wire  imaenc_pkg::kind_t  channel_mode,
  input  wire                      queue_full,
  output imaenc_pkg::push_t        push
);
  import imaenc_pkg::*;

  logic known_mode;

  always_comb begin
    case (channel_mode)
      KindMono, KindStereo, KindQuad: known_mode = 1'b1;
      default:                        known_mode = 1'b0;
    endcase
  end

  // held off during reset so no transfer is taken and lost
  assign s_axis_tready = !queue_full && !rst;

  // unused mode code: transfer taken, frame discarded
  assign push.push           = s_axis_tvalid && s_axis_tready && known_mode;
  assign push.frame.kind     = channel_mode;
  assign push.frame.sample_a = s_axis_tdata[15:0];
  assign push.frame.sample_b = s_axis_tdata[31:16];
  assign push.frame.sample_c = s_axis_tdata[47:32];
  assign push.frame.sample_d = s_axis_tdata[63:48];

endmodule

`default_nettype wire

### rtl/imaenc_queue.sv
// Short frame queue between front and back end
`default_nettype none

module imaenc_queue #(
  parameter int DEPTH = 4
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire  imaenc_pkg::push_t   push,
  output logic                      full,
  input  wire                       pop,
  output imaenc_pkg::head_t         head
);
  import imaenc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  frame_t            entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_pop;

  assign full       = (count == CntW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.frame = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.push) begin
      entries[wr_ptr] <= push.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/imaenc_back.sv
// Back end: two encoder lanes, per-channel state, output register
`default_nettype none

module imaenc_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  imaenc_pkg::head_t head,
  output logic                 pop,
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);
  import imaenc_pkg::*;

  logic signed [15:0] pred [4];
  logic [6:0]         pos  [4];
  logic               phase;     // second pass: mono second sample, quad center/LFE
  logic [3:0]         lo_code;   // mono first-sample code, held for the second pass
  logic               out_free;
  logic               take;
  logic               emit;
  logic               is_quad;
  logic               is_mono;
  logic               two_pass;
  logic signed [15:0] smp0, smp1, pred0, pred1;
  logic [6:0]         pos0, pos1;
  enc_res_t           r0, r1;

  assign is_quad  = (head.frame.kind == KindQuad);
  assign is_mono  = (head.frame.kind == KindMono);
  assign two_pass = is_quad || is_mono;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign take     = head.valid && out_free;
  assign emit     = !(is_mono && !phase);
  assign pop      = take && !(two_pass && !phase);

  always_comb begin
    // lane 0: channel 0 (mono: sample_a, then sample_b), or channel 2
    if (phase && !is_mono) begin
      smp0  = head.frame.sample_c;
      pred0 = pred[2];
      pos0  = pos[2];
    end else begin
      smp0  = phase ? head.frame.sample_b : head.frame.sample_a;
      pred0 = pred[0];
      pos0  = pos[0];
    end
    // lane 1: channel 1 or channel 3; its result is unused in mono
    smp1  = phase ? head.frame.sample_d : head.frame.sample_b;
    pred1 = phase ? pred[3] : pred[1];
    pos1  = phase ? pos[3]  : pos[1];
    r0    = encode_nibble(smp0, pred0, pos0);
    r1    = encode_nibble(smp1, pred1, pos1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        pred[i] <= '0;
        pos[i]  <= '0;
      end
      phase         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (take) begin
        if (is_mono) begin
          pred[0] <= r0.pred;
          pos[0]  <= r0.pos;
        end else if (phase) begin
          pred[2] <= r0.pred;
          pos[2]  <= r0.pos;
          pred[3] <= r1.pred;
          pos[3]  <= r1.pos;
        end else begin
          pred[0] <= r0.pred;
          pos[0]  <= r0.pos;
          pred[1] <= r1.pred;
          pos[1]  <= r1.pos;
        end
        phase <= two_pass && !phase;
      end
      if (out_free) begin
        m_axis_tvalid <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_mono && !phase) begin
      lo_code <= r0.code;
    end
    if (take && emit) begin
      m_axis_tdata <= is_mono ? {r0.code, lo_code} : {r1.code, r0.code};
      m_axis_tuser <= is_quad && phase;
      m_axis_tlast <= !(is_quad && !phase);
    end
  end

endmodule

`default_nettype wire

### rtl/imaenc_checker.sv
// Port-level checker for the encoder output stream, bound to the top level
`default_nettype none

`include "ima_adpcm_multichannel_encoder_assert.svh"

module imaenc_checker (
  input wire       clk,
  input wire       rst,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata,
  input wire       m_axis_tuser,
  input wire       m_axis_tlast
);

  `IMAENC_ASSERT_NEXT(a_valid_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped while stalled")
  `IMAENC_ASSERT_NEXT(a_payload_held, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output payload moved while stalled")
  `IMAENC_ASSERT_NOW(a_rear_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "center/LFE byte not marked last")
  `IMAENC_ASSERT_NEXT(a_front_then_rear, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tuser, "front pair byte not followed by center/LFE byte")

endmodule

bind ima_adpcm_multichannel_encoder imaenc_checker u_imaenc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
